FILE: hw/rtl/dtfe_pkg.sv
`default_nettype none

package dtfe_pkg;

   localparam logic [4:0] DAY_31   = 5'd31;
   localparam logic [4:0] DAY_30   = 5'd30;
   localparam logic [4:0] DAY_29   = 5'd29;
   localparam logic [4:0] DAY_28   = 5'd28;
   localparam int         YEAR_4   = 4;
   localparam logic [6:0] YEAR_99  = 7'd99;
   localparam logic [4:0] HOUR_23  = 5'd23;
   localparam logic [5:0] MINU_59  = 6'd59;
   localparam logic [5:0] SEC_59   = 6'd59;
   localparam logic [3:0] MONTH_12 = 4'd12;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [2:0] {
      CMD_NOP    = 3'd0,
      CMD_UP     = 3'd1,
      CMD_DOWN   = 3'd2,
      CMD_NEXT   = 3'd3,
      CMD_COMMIT = 3'd4,
      CMD_LOAD   = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      SEL_DAY    = 3'd0,
      SEL_MONTH  = 3'd1,
      SEL_YEAR   = 3'd2,
      SEL_HOUR   = 3'd3,
      SEL_MINUTE = 3'd4,
      SEL_SECOND = 3'd5
   } field_type;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
   } dt_type;

   typedef struct packed {
      field_type sel;
      dt_type    dt;
   } editor_state_type;

   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_FEB = 4'd2;

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic [6:0] year);
      logic [4:0] len;
      if (month == MONTH_APR || month == MONTH_JUN || month == MONTH_SEP ||
          month == MONTH_NOV) begin
         len = DAY_30;
      end else if (month == MONTH_FEB) begin
         len = ((year % YEAR_4) == 0) ? DAY_29 : DAY_28;
      end else begin
         len = DAY_31;
      end
      return len;
   endfunction

   // step by one with wraparound between lo and hi
   function automatic logic [6:0] step_wrap(input logic [6:0] v, input logic [6:0] lo,
                                            input logic [6:0] hi, input logic up);
      logic [6:0] r;
      if (up) begin
         r = (v < hi) ? 7'(v + 7'd1) : lo;
      end else begin
         r = (v > lo) ? 7'(v - 7'd1) : hi;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/dtfe_update.sv
`default_nettype none

module dtfe_update (
   input  wire logic [2:0]                cmd,
   input  wire dtfe_pkg::dt_type          load,
   input  wire dtfe_pkg::editor_state_type cur,
   output dtfe_pkg::editor_state_type     nxt,
   output logic                           commit
);

   logic       up;
   logic [4:0] len_cur;
   logic [4:0] len_mon;
   logic [4:0] len_yr;
   logic [3:0] month_step;
   logic [6:0] year_step;
   logic [4:0] day_step;
   logic [4:0] hour_step;
   logic [5:0] minute_step;
   logic [5:0] second_step;
   dtfe_pkg::dt_type sat_load;

   assign up = (cmd == dtfe_pkg::CMD_UP);

   assign len_cur     = dtfe_pkg::month_len(cur.dt.month, cur.dt.year);
   assign day_step    = 5'(dtfe_pkg::step_wrap(7'(cur.dt.day), 7'd1, 7'(len_cur), up));
   assign month_step  = 4'(dtfe_pkg::step_wrap(7'(cur.dt.month), 7'd1,
                                               7'(dtfe_pkg::MONTH_12), up));
   assign year_step   = dtfe_pkg::step_wrap(cur.dt.year, 7'd0, dtfe_pkg::YEAR_99, up);
   assign hour_step   = 5'(dtfe_pkg::step_wrap(7'(cur.dt.hour), 7'd0,
                                               7'(dtfe_pkg::HOUR_23), up));
   assign minute_step = 6'(dtfe_pkg::step_wrap(7'(cur.dt.minute), 7'd0,
                                               7'(dtfe_pkg::MINU_59), up));
   assign second_step = 6'(dtfe_pkg::step_wrap(7'(cur.dt.second), 7'd0,
                                               7'(dtfe_pkg::SEC_59), up));
   assign len_mon     = dtfe_pkg::month_len(month_step, cur.dt.year);
   assign len_yr      = dtfe_pkg::month_len(cur.dt.month, year_step);

   // loaded day is not clamped to the loaded month
   always_comb begin
      sat_load.day    = (load.day == 5'd0) ? 5'd1 : load.day;
      sat_load.month  = (load.month == 4'd0) ? 4'd1 :
                        (load.month > dtfe_pkg::MONTH_12) ? dtfe_pkg::MONTH_12 : load.month;
      sat_load.year   = (load.year > dtfe_pkg::YEAR_99) ? dtfe_pkg::YEAR_99 : load.year;
      sat_load.hour   = (load.hour > dtfe_pkg::HOUR_23) ? dtfe_pkg::HOUR_23 : load.hour;
      sat_load.minute = (load.minute > dtfe_pkg::MINU_59) ? dtfe_pkg::MINU_59 : load.minute;
      sat_load.second = (load.second > dtfe_pkg::SEC_59) ? dtfe_pkg::SEC_59 : load.second;
   end

   always_comb begin
      nxt    = cur;
      commit = 1'b0;
      unique case (cmd)
         dtfe_pkg::CMD_UP, dtfe_pkg::CMD_DOWN: begin
            unique case (cur.sel)
               dtfe_pkg::SEL_DAY: begin
                  nxt.dt.day = day_step;
               end
               dtfe_pkg::SEL_MONTH: begin
                  nxt.dt.month = month_step;
                  nxt.dt.day   = (cur.dt.day > len_mon) ? len_mon : cur.dt.day;
               end
               dtfe_pkg::SEL_YEAR: begin
                  nxt.dt.year = year_step;
                  nxt.dt.day  = (cur.dt.day > len_yr) ? len_yr : cur.dt.day;
               end
               dtfe_pkg::SEL_HOUR: begin
                  nxt.dt.hour = hour_step;
               end
               dtfe_pkg::SEL_MINUTE: begin
                  nxt.dt.minute = minute_step;
               end
               default: begin
                  nxt.dt.second = second_step;
               end
            endcase
         end
         dtfe_pkg::CMD_NEXT: begin
            nxt.sel = (cur.sel >= dtfe_pkg::SEL_SECOND) ? dtfe_pkg::SEL_DAY
                                                         : dtfe_pkg::field_type'(cur.sel + 3'd1);
         end
         dtfe_pkg::CMD_COMMIT: begin
            commit  = 1'b1;
            nxt.sel = dtfe_pkg::SEL_DAY;
         end
         dtfe_pkg::CMD_LOAD: begin
            nxt.dt = sat_load;
         end
         default: begin
            // refresh and unused codes leave the state alone
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/date_time_field_editor.sv
`default_nettype none

// channel   direction  transaction
// req_      in         one button event: command in tuser, load values in tdata
// rsp_      out        edited date, time and selected field after the event
//
// one transaction per cycle in each direction while results are taken; a req reaches rsp
// through the input register, then update logic into the result register and state
// reset clears the edit state to day 1, month 1, year 0, 00:00:00, day selected
// rsp_tready low holds the result; one more event waits in the input register,
// then req_tready drops until the result is taken
module date_time_field_editor (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // day[4:0] month[8:5] year[15:9] hour[20:16] minute[26:21] second[32:27]
   input  wire logic [dtfe_pkg::REQ_TDATA_W-1:0] req_tdata,
   // command[2:0]
   input  wire logic [2:0]                       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // day[4:0] month[8:5] year[15:9] hour[20:16] minute[26:21] second[32:27]
   // selected_field[35:33]
   output logic [dtfe_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // commit[0]
   output logic                                  rsp_tuser
);

   logic                       in_valid_ff;
   logic                       in_valid_in;
   logic [2:0]                 in_cmd_ff;
   dtfe_pkg::dt_type           in_load_ff;
   dtfe_pkg::editor_state_type state_ff;
   dtfe_pkg::editor_state_type state_in;
   logic                       commit_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [dtfe_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic                       rsp_commit_ff;
   logic                       advance;
   logic                       req_take;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff  <= req_tuser;
         in_load_ff <= dtfe_pkg::dt_type'(req_tdata[32:0]);
      end
   end

   dtfe_update u_update (
      .cmd    (in_cmd_ff),
      .load   (in_load_ff),
      .cur    (state_ff),
      .nxt    (state_in),
      .commit (commit_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.sel       <= dtfe_pkg::SEL_DAY;
         state_ff.dt.day    <= 5'd1;
         state_ff.dt.month  <= 4'd1;
         state_ff.dt.year   <= 7'd0;
         state_ff.dt.hour   <= 5'd0;
         state_ff.dt.minute <= 6'd0;
         state_ff.dt.second <= 6'd0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff   <= {4'd0, state_in};
         rsp_commit_ff <= commit_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_commit_ff;

   // a committed result always shows day selected
   a_commit_sel : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[35:33] == dtfe_pkg::SEL_DAY)
      else $error("commit result without day selected");

   // edit state stays in range
   a_state_range : assert property (@(posedge clock) disable iff (reset)
      state_ff.dt.day != 5'd0 && state_ff.dt.month != 4'd0 &&
      state_ff.dt.month <= dtfe_pkg::MONTH_12 && state_ff.dt.hour <= dtfe_pkg::HOUR_23 &&
      state_ff.sel <= dtfe_pkg::SEL_SECOND)
      else $error("edit state out of range");

   // an event leaving the input register shows up as a result next cycle
   a_advance : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result lost after update");

   // state only moves when an event is processed
   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |=> $stable(state_ff))
      else $error("state changed without an event");

endmodule

`default_nettype wire
